// ===== hdl/nec_pkg.sv =====
// Shared constants, level codes and the gamma table function for the EGA color matcher.
`default_nettype none

package nec_pkg;

    localparam int unsigned PALETTE_ENTRIES     = 64;
    localparam int unsigned GAMMA_FRAC_BITS_DEF = 16;
    localparam int unsigned PIXEL_W             = 8;
    localparam int unsigned ROM_DEPTH           = 2 ** PIXEL_W;
    localparam int unsigned INDEX_W             = $clog2(PALETTE_ENTRIES);
    localparam int unsigned CHANNELS            = 3;
    localparam int unsigned LEVELS              = 4;
    localparam int unsigned IN_TDATA_W          = 24;
    localparam int unsigned OUT_TDATA_W         = 8;

    // Level code per channel: bit 1 is the upper-case (170) bit, bit 0 the lower-case (85) bit.
    typedef enum logic [1:0] {
        LVL_0   = 2'd0,
        LVL_85  = 2'd1,
        LVL_170 = 2'd2,
        LVL_255 = 2'd3
    } t_level;

    localparam int unsigned LEVEL_SRGB [LEVELS] = '{0, 85, 170, 255};

    // round((idx/255)^2.2 * 2^frac), exact half up: integer root search at F+1 bits, then halve.
    function automatic logic [31:0] gamma_entry(input int unsigned idx, input int unsigned frac);
        logic [255:0] rhs;
        logic [255:0] lhs;
        logic [255:0] big_i;
        logic [255:0] big_s;
        logic [255:0] big_m;
        logic [31:0]  scale;
        logic [31:0]  lo;
        logic [31:0]  hi;
        logic [31:0]  mid;
        int           k;
        scale = 32'd1 << (frac + 1);
        big_i = 256'(idx);
        big_s = 256'(scale);
        rhs   = 256'd1;
        for (k = 0; k < 11; k++) rhs = rhs * big_i;
        for (k = 0; k < 5; k++)  rhs = rhs * big_s;
        lo = 32'd0;
        hi = scale;
        while (lo < hi) begin
            mid   = lo + ((hi - lo + 32'd1) >> 1);
            big_m = 256'(mid);
            lhs   = 256'd1;
            for (k = 0; k < 5; k++)  lhs = lhs * big_m;
            for (k = 0; k < 11; k++) lhs = lhs * 256'd255;
            if (lhs <= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 32'd1;
            end
        end
        return (lo + 32'd1) >> 1;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/nec_gamma_lut.sv =====
// Stage 1: linearize the three sRGB channels through the constant gamma table.
`default_nettype none

module nec_gamma_lut
    import nec_pkg::*;
#(
    parameter int unsigned GAMMA_FRAC_BITS = GAMMA_FRAC_BITS_DEF,
    localparam int unsigned GAMMA_W        = GAMMA_FRAC_BITS + 1
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic [CHANNELS-1:0][PIXEL_W-1:0]       i_level,
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic      [CHANNELS-1:0][GAMMA_W-1:0]       o_gamma
);

    logic [GAMMA_W-1:0]                 rom [ROM_DEPTH];
    logic                               r_valid;
    logic [CHANNELS-1:0][GAMMA_W-1:0]   r_gamma;
    logic [CHANNELS-1:0][GAMMA_W-1:0]   n_gamma;

    for (genvar gi = 0; gi < ROM_DEPTH; gi++) begin : g_rom
        localparam logic [GAMMA_W-1:0] ENTRY = GAMMA_W'(gamma_entry(gi, GAMMA_FRAC_BITS));
        assign rom[gi] = ENTRY;
    end

    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            n_gamma[c] = rom[i_level[c]];
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_gamma <= n_gamma;
        end
    end

    assign o_valid = r_valid;
    assign o_gamma = r_gamma;

endmodule

`default_nettype wire

// ===== hdl/nec_level_diff.sv =====
// Stage 2: distance of each linear channel to the four linear palette levels.
`default_nettype none

module nec_level_diff
    import nec_pkg::*;
#(
    parameter int unsigned GAMMA_FRAC_BITS = GAMMA_FRAC_BITS_DEF,
    localparam int unsigned GAMMA_W        = GAMMA_FRAC_BITS + 1
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_rst_n,
    input  wire logic                                           i_valid,
    output logic                                                o_ready,
    input  wire logic [CHANNELS-1:0][GAMMA_W-1:0]               i_gamma,
    output logic                                                o_valid,
    input  wire logic                                           i_ready,
    output logic      [CHANNELS-1:0][LEVELS-1:0][GAMMA_W-1:0]   o_diff
);

    logic                                           r_valid;
    logic [CHANNELS-1:0][LEVELS-1:0][GAMMA_W-1:0]   r_diff;
    logic [CHANNELS-1:0][LEVELS-1:0][GAMMA_W-1:0]   n_diff;

    // Squares order the same way as magnitudes, so magnitudes are enough to rank levels.
    for (genvar lv = 0; lv < LEVELS; lv++) begin : g_lvl
        localparam logic [GAMMA_W-1:0] LVL_LIN =
            GAMMA_W'(gamma_entry(LEVEL_SRGB[lv], GAMMA_FRAC_BITS));
        for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_ch
            assign n_diff[ch][lv] = (i_gamma[ch] >= LVL_LIN) ? (i_gamma[ch] - LVL_LIN)
                                                             : (LVL_LIN - i_gamma[ch]);
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_diff <= n_diff;
        end
    end

    assign o_valid = r_valid;
    assign o_diff  = r_diff;

endmodule

`default_nettype wire

// ===== hdl/nec_level_pick.sv =====
// Stage 3: pick the nearest level per channel and pack the EGA code into the output register.
`default_nettype none

module nec_level_pick
    import nec_pkg::*;
#(
    parameter int unsigned GAMMA_FRAC_BITS = GAMMA_FRAC_BITS_DEF,
    localparam int unsigned GAMMA_W        = GAMMA_FRAC_BITS + 1
) (
    input  wire logic                                           i_clk,
    input  wire logic                                           i_rst_n,
    input  wire logic                                           i_valid,
    output logic                                                o_ready,
    input  wire logic [CHANNELS-1:0][LEVELS-1:0][GAMMA_W-1:0]   i_diff,
    output logic                                                o_valid,
    input  wire logic                                           i_ready,
    output logic      [INDEX_W-1:0]                             o_index
);

    logic                   r_valid;
    logic [INDEX_W-1:0]     r_index;
    logic [INDEX_W-1:0]     n_index;
    t_level                 sel   [CHANNELS];
    logic [GAMMA_W-1:0]     best  [CHANNELS];

    // Visit levels in ascending code order (lower-case bit is the more significant),
    // so a strict compare leaves ties on the lowest code.
    always_comb begin
        for (int c = 0; c < CHANNELS; c++) begin
            sel[c]  = LVL_0;
            best[c] = i_diff[c][LVL_0];
            if (i_diff[c][LVL_170] < best[c]) begin
                sel[c]  = LVL_170;
                best[c] = i_diff[c][LVL_170];
            end
            if (i_diff[c][LVL_85] < best[c]) begin
                sel[c]  = LVL_85;
                best[c] = i_diff[c][LVL_85];
            end
            if (i_diff[c][LVL_255] < best[c]) begin
                sel[c]  = LVL_255;
                best[c] = i_diff[c][LVL_255];
            end
        end
    end

    // Code bits from high to low: r g b R G B; channel 0 red, 1 green, 2 blue.
    assign n_index = {sel[0][0], sel[1][0], sel[2][0], sel[0][1], sel[1][1], sel[2][1]};

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_index <= n_index;
        end
    end

    assign o_valid = r_valid;
    assign o_index = r_index;

endmodule

`default_nettype wire

// ===== hdl/nearest_ega_color_match.sv =====
// Top level of the nearest EGA color matcher: three-stage pixel pipeline.
//
//  channel    dir  tdata bits (low to high)                      meaning
//  s_axis     in   [7:0] red, [15:8] green, [23:16] blue         one sRGB pixel
//  m_axis     out  [5:0] ega_index (rgbRGB), [7:6] zero          nearest EGA code
//
//  Throughput is one pixel per cycle while m_axis_tready stays high; a beat passes
//  three registers: gamma table, level distances, level pick into the output register.
//  Each stage holds its own valid bit and takes a new beat whenever it is empty or
//  its successor takes its beat; ready ripples back combinationally from
//  m_axis_tready to s_axis_tready.
//  A low m_axis_tready stalls stages back to front; nothing is dropped or repeated.
//  i_rst_n (synchronous, active low) clears the valid bits; data registers keep state.
`default_nettype none

module nearest_ega_color_match
    import nec_pkg::*;
#(
    parameter int unsigned GAMMA_FRAC_BITS = GAMMA_FRAC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0]      i_s_axis_tdata,   // red, green, blue
    output logic                            o_m_axis_tvalid,
    input  wire logic                       i_m_axis_tready,
    output logic      [OUT_TDATA_W-1:0]     o_m_axis_tdata    // ega_index, zero pad
);

    localparam int unsigned GAMMA_W = GAMMA_FRAC_BITS + 1;

    logic [CHANNELS-1:0][PIXEL_W-1:0]               pix_level;
    logic                                           s1_valid;
    logic                                           s1_ready;
    logic [CHANNELS-1:0][GAMMA_W-1:0]               s1_gamma;
    logic                                           s2_valid;
    logic                                           s2_ready;
    logic [CHANNELS-1:0][LEVELS-1:0][GAMMA_W-1:0]   s2_diff;
    logic [INDEX_W-1:0]                             out_index;

    // Red in the lowest byte of the input beat.
    assign pix_level = i_s_axis_tdata[CHANNELS*PIXEL_W-1:0];

    nec_gamma_lut #(
        .GAMMA_FRAC_BITS (GAMMA_FRAC_BITS)
    ) u_gamma (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_level (pix_level),
        .o_valid (s1_valid),
        .i_ready (s1_ready),
        .o_gamma (s1_gamma)
    );

    nec_level_diff #(
        .GAMMA_FRAC_BITS (GAMMA_FRAC_BITS)
    ) u_diff (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s1_valid),
        .o_ready (s1_ready),
        .i_gamma (s1_gamma),
        .o_valid (s2_valid),
        .i_ready (s2_ready),
        .o_diff  (s2_diff)
    );

    nec_level_pick #(
        .GAMMA_FRAC_BITS (GAMMA_FRAC_BITS)
    ) u_pick (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s2_valid),
        .o_ready (s2_ready),
        .i_diff  (s2_diff),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_index (out_index)
    );

    // Zero-pad the code up to a whole byte.
    assign o_m_axis_tdata = {(OUT_TDATA_W - INDEX_W)'(0), out_index};

    // A stalled stage keeps its beat.
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_valid && !s1_ready |=> s1_valid && $stable(s1_gamma))
        else $error("stage 1 lost or changed a stalled beat");

    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_valid && !s2_ready |=> s2_valid && $stable(s2_diff))
        else $error("stage 2 lost or changed a stalled beat");

    // A beat leaving stage 2 lands in the output register.
    a_s2_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_valid && s2_ready |=> o_m_axis_tvalid)
        else $error("beat from stage 2 missing at the output");

    // Reset empties the pipeline.
    a_rst_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid && !s1_valid && !s2_valid)
        else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the nearest EGA color matcher.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import nec_pkg::*;

    localparam int unsigned LIN_FRAC     = GAMMA_FRAC_BITS_DEF;
    localparam int unsigned RANDOM_PIXELS = 1100;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned IDLE_PCT     = 11;
    localparam int unsigned QUIET_FROM   = 100;    // no idling on either side in this window
    localparam int unsigned QUIET_TO     = 500;
    localparam int unsigned HOLD_AFTER   = 500;    // pixels accepted before the long back-pressure
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 12;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;    // red, green, blue
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;    // ega_index, zero pad

    // Linearized channel table, built once at time zero.
    logic [31:0]            lin_lut [ROM_DEPTH];

    logic [IN_TDATA_W-1:0]  pixel_queue [$];
    logic [INDEX_W-1:0]     code_queue  [$];

    logic                   in_beat;
    int unsigned            cycle_count;
    int unsigned            pixels_in;
    int unsigned            codes_out;
    int unsigned            error_count;
    logic [63:0]            codes_seen;
    int unsigned            hold_left;
    logic                   hold_done;
    logic [INDEX_W-1:0]     want_code;

    nearest_ega_color_match u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // Largest m with (m / 2^(F+1)) <= (idx/255)^(11/5), found bit by bit, then
    // halved with rounding: round((idx/255)^2.2 * 2^F), half up.
    function automatic logic [31:0] linearize(input int unsigned idx);
        logic [199:0] bound;
        logic [199:0] k255;
        logic [199:0] trial_pow;
        logic [31:0]  acc;
        logic [31:0]  trial;
        int           n;
        int           b;
        bound = 200'd1;
        k255  = 200'd1;
        for (n = 0; n < 11; n++) begin
            bound = bound * 200'(idx);
            k255  = k255 * 200'd255;
        end
        bound = bound << (5 * (LIN_FRAC + 1));
        acc = 32'd0;
        for (b = LIN_FRAC + 1; b >= 0; b--) begin
            trial = acc | (32'd1 << b);
            if (trial <= (32'd1 << (LIN_FRAC + 1))) begin
                trial_pow = 200'd1;
                for (n = 0; n < 5; n++) trial_pow = trial_pow * 200'(trial);
                if (trial_pow * k255 <= bound) acc = trial;
            end
        end
        return (acc + 32'd1) >> 1;
    endfunction

    function automatic logic [63:0] sq_gap(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] d;
        d = (a >= b) ? 64'(a - b) : 64'(b - a);
        return d * d;
    endfunction

    // Nearest EGA code: scan all 64 codes, keep the first of equal distances.
    function automatic logic [INDEX_W-1:0] nearest_code(input logic [IN_TDATA_W-1:0] px);
        logic [INDEX_W-1:0] best_code;
        logic [63:0]        best_dist;
        logic [63:0]        gap_sum;
        logic [INDEX_W-1:0] c;
        t_level             lr;
        t_level             lg;
        t_level             lb;
        int                 n;
        best_code = '0;
        best_dist = '0;
        for (n = 0; n < PALETTE_ENTRIES; n++) begin
            c  = INDEX_W'(n);
            // upper-case bit is worth 170, lower-case 85
            lr = t_level'({c[2], c[5]});
            lg = t_level'({c[1], c[4]});
            lb = t_level'({c[0], c[3]});
            gap_sum = sq_gap(lin_lut[px[7:0]],   lin_lut[LEVEL_SRGB[lr]])
                    + sq_gap(lin_lut[px[15:8]],  lin_lut[LEVEL_SRGB[lg]])
                    + sq_gap(lin_lut[px[23:16]], lin_lut[LEVEL_SRGB[lb]]);
            if (n == 0 || gap_sum < best_dist) begin
                best_dist = gap_sum;
                best_code = c;
            end
        end
        return best_code;
    endfunction

    // Channel value close to one of the four EGA levels or to a midpoint between them.
    function automatic logic [7:0] near_level(input bit midpoint);
        int base;
        int v;
        if (midpoint) begin
            base = 42 + 85 * $urandom_range(0, 2);
            v    = base + $urandom_range(0, 5) - 2;
        end else begin
            base = LEVEL_SRGB[$urandom_range(0, 3)];
            v    = base + $urandom_range(0, 24) - 12;
        end
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    function automatic logic [IN_TDATA_W-1:0] rgb(input int r, input int g, input int b);
        return {8'(b), 8'(g), 8'(r)};
    endfunction

    // Append one pixel to the tail of the send queue.
    task automatic queue_pixel(input logic [IN_TDATA_W-1:0] px);
        pixel_queue.insert(pixel_queue.size(), px);
    endtask

    task automatic note_error(input string what);
        error_count++;
        if (error_count <= 10) $display("tb_top: mismatch at cycle %0d: %s", cycle_count, what);
    endtask

    function automatic bit quiet_window();
        return cycle_count >= QUIET_FROM && cycle_count < QUIET_TO;
    endfunction

    // Sender: advance to the next pixel once the current beat is taken; idle at random.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || in_beat) begin
            if (pixel_queue.size() > 0 &&
                (quiet_window() || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pixel_queue.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Long back-pressure: once enough pixels have gone in, hold the receiver off.
    always @(negedge i_clk) begin
        if (!hold_done && pixels_in >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Receiver: stall at random, never during the quiet window, always during the hold.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= (hold_left == 0) &&
                        (quiet_window() || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Monitor: predict on every input beat, check every output beat in order.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_top: timeout after %0d cycles", cycle_count);
            $display("tb_top: done, errors");
            $finish;
        end
        in_beat <= i_rst_n && s_tvalid && s_tready;
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                code_queue.insert(code_queue.size(), nearest_code(s_tdata));
                pixels_in <= pixels_in + 1;
            end
            if (m_tvalid && m_tready) begin
                codes_out <= codes_out + 1;
                if (code_queue.size() == 0) begin
                    note_error($sformatf("unexpected result 0x%02h", m_tdata));
                end else begin
                    want_code = code_queue.pop_front();
                    codes_seen[want_code] = 1'b1;
                    if (m_tdata[INDEX_W-1:0] !== want_code)
                        note_error($sformatf("ega_index expected %0d got %0d",
                                             want_code, m_tdata[INDEX_W-1:0]));
                    if (m_tdata[OUT_TDATA_W-1:INDEX_W] !== '0)
                        note_error($sformatf("pad bits expected 0 got %b",
                                             m_tdata[OUT_TDATA_W-1:INDEX_W]));
                end
            end
        end
    end

    initial begin
        int n;
        int mode;
        i_rst_n     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        m_tready    = 1'b0;
        in_beat     = 1'b0;
        cycle_count = 0;
        pixels_in   = 0;
        codes_out   = 0;
        error_count = 0;
        codes_seen  = '0;
        hold_left   = 0;
        hold_done   = 1'b0;

        for (n = 0; n < ROM_DEPTH; n++) lin_lut[n] = linearize(n);

        // Directed: corners of the cube, exact EGA levels, the points halfway
        // between levels where near-ties fall, and single hot channels.
        for (n = 0; n < 8; n++) queue_pixel(rgb(n[0] * 255, n[1] * 255, n[2] * 255));
        queue_pixel(rgb(85, 85, 85));
        queue_pixel(rgb(170, 170, 170));
        queue_pixel(rgb(255, 85, 85));
        queue_pixel(rgb(170, 85, 0));
        queue_pixel(rgb(42, 43, 42));
        queue_pixel(rgb(127, 128, 127));
        queue_pixel(rgb(212, 213, 212));
        queue_pixel(rgb(1, 0, 254));
        queue_pixel(rgb(128, 64, 32));
        queue_pixel(rgb(16, 8, 4));
        queue_pixel(rgb(86, 169, 84));
        queue_pixel(rgb(171, 254, 1));
        queue_pixel(rgb(200, 200, 0));
        queue_pixel(rgb(0, 127, 255));

        // Random: free pixels, pixels near the palette levels, pixels near midpoints.
        for (n = 0; n < RANDOM_PIXELS; n++) begin
            mode = $urandom_range(0, 9);
            if (mode < 4)
                queue_pixel(IN_TDATA_W'($urandom));
            else if (mode < 8)
                queue_pixel({near_level(1'b0), near_level(1'b0), near_level(1'b0)});
            else
                queue_pixel({near_level(mode[0]), near_level(1'b1), near_level(1'b1)});
        end

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: all pixels sent, all codes back, then a few quiet cycles.
        while (pixel_queue.size() > 0 || s_tvalid) @(posedge i_clk);
        while (code_queue.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (code_queue.size() > 0)
            note_error($sformatf("%0d results never arrived", code_queue.size()));

        $display("tb_top: %0d pixels matched, %0d codes checked, %0d of 64 EGA codes hit",
                 pixels_in, codes_out, $countones(codes_seen));
        $display("tb_top: random idling on both sides plus one %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (error_count == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: %0d mismatches", error_count);
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
